// ----- hw/rtl/rgbhsl_pkg.sv -----
package rgbhsl_pkg;

    localparam int CH_W     = 8;
    localparam int SUM_W    = CH_W + 1;
    localparam int HUE_W    = 15;
    localparam int PCT_W    = 14;

    localparam int HALF_SUM = 255;
    localparam int FULL_SUM = 510;

    localparam int HUE_FULL  = 23040;
    localparam int HUE_SIXTH = 3840;
    localparam int HUE_SCALE2 = 2 * HUE_SIXTH;
    localparam int SAT_SCALE2 = 20000;

    // lightness = floor((LIGHT_MUL * sum + LIGHT_ADD) / LIGHT_DIV)
    localparam int LIGHT_MUL   = 5000;
    localparam int LIGHT_ADD   = 127;
    localparam int LIGHT_DIV   = 255;
    localparam int LIGHT_RECIP = 257;
    localparam int LIGHT_SHIFT = 16;
    localparam int LY_W        = 22;

    localparam int NUM_W    = 23;
    localparam int DEN_W    = CH_W + 1;
    localparam int DIV_BITS = 14;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        SEC_RED   = 2'b00,
        SEC_GREEN = 2'b01,
        SEC_BLUE  = 2'b10
    } t_sector;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] lightness;
    } t_out_item;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CH_W-1:0]  spread;
        logic [CH_W-1:0]  den;
        logic [CH_W-1:0]  diff;
        t_sector          sector;
        logic             neg;
    } t_task;

    typedef struct packed {
        t_sector          sector;
        logic             neg;
        logic             grey;
        logic [LY_W-1:0]  y;
        logic [PCT_W-1:0] light;
    } t_side;

    function automatic logic [HUE_W:0] sector_base(input t_sector sec);
        logic [HUE_W:0] base;
        unique case (sec)
            SEC_RED:   base = '0;
            SEC_GREEN: base = (HUE_W+1)'(2 * HUE_SIXTH);
            SEC_BLUE:  base = (HUE_W+1)'(4 * HUE_SIXTH);
            default:   base = '0;
        endcase
        return base;
    endfunction

endpackage

// ----- hw/rtl/rgb_to_hsl_converter.sv -----
// Throughput: one item per cycle while the output is not stalled; the two 14-stage restoring dividers set the depth.
// A four-entry queue between the classify stage and the divider pipeline absorbs stalls.
// Reset: synchronous active-low i_rst_n empties the queue and drops all items in flight.
module rgb_to_hsl_converter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rgbhsl_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rgbhsl_pkg::t_out_item o_out_item
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    rgbhsl_pkg::t_task fr_task;
    rgbhsl_pkg::t_task q_task;

    rgbhsl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_item   (i_in_item),
        .o_stall  (o_in_stall),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_task   (fr_task)
    );

    rgbhsl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (fr_task),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_task)
    );

    rgbhsl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_task    (q_task),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_item)
    );

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.hue < 15'(rgbhsl_pkg::HUE_FULL))
        else $error("hue out of range");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.saturation <= 14'd10000
                         && o_out_item.lightness <= 14'd10000))
        else $error("saturation or lightness out of range");

    a_queue_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_queue_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

endmodule

// ----- hw/rtl/rgbhsl_div.sv -----
module rgbhsl_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [rgbhsl_pkg::NUM_W-1:0]      i_num,
    input  logic [rgbhsl_pkg::DEN_W-1:0]      i_den,
    output logic [rgbhsl_pkg::DIV_BITS-1:0]   o_quo
);

    localparam int NW = rgbhsl_pkg::NUM_W;
    localparam int QB = rgbhsl_pkg::DIV_BITS;
    localparam int DW = rgbhsl_pkg::DEN_W;

    logic [NW-1:0] r_rem [QB-1];
    logic [QB-1:0] r_quo [QB];
    logic [DW-1:0] r_den [QB-1];

    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int SH = QB - 1 - j;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [NW-1:0] trial;
        logic [QB-1:0] quo_in;
        logic          fit;

        if (j == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
        end

        assign trial = NW'(den_in) << SH;
        assign fit   = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= quo_in | (fit ? (QB'(1) << SH) : '0);
            end
        end

        if (j < QB - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= fit ? rem_in - trial : rem_in;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            for (int k = 1; k < QB - 1; k++) begin
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule

// ----- hw/rtl/rgbhsl_front.sv -----
module rgbhsl_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rgbhsl_pkg::t_in_item  i_item,
    output logic                  o_stall,
    input  logic                  i_q_full,
    output logic                  o_push,
    output rgbhsl_pkg::t_task     o_task
);

    localparam int CW = rgbhsl_pkg::CH_W;
    localparam int SW = rgbhsl_pkg::SUM_W;

    logic              r_valid;
    rgbhsl_pkg::t_task r_task;
    rgbhsl_pkg::t_task n_task;
    logic              take;

    logic [CW-1:0] mx;
    logic [CW-1:0] mn;
    logic [CW-1:0] pos;
    logic [CW-1:0] neg;
    logic [SW-1:0] sum;

    always_comb begin
        mx = i_item.red;
        mn = i_item.red;
        if (i_item.green > mx) mx = i_item.green;
        if (i_item.blue > mx)  mx = i_item.blue;
        if (i_item.green < mn) mn = i_item.green;
        if (i_item.blue < mn)  mn = i_item.blue;
        sum = SW'(mx) + SW'(mn);

        priority if (mx == i_item.red) begin
            pos = i_item.green;
            neg = i_item.blue;
            n_task.sector = rgbhsl_pkg::SEC_RED;
        end else if (mx == i_item.green) begin
            pos = i_item.blue;
            neg = i_item.red;
            n_task.sector = rgbhsl_pkg::SEC_GREEN;
        end else begin
            pos = i_item.red;
            neg = i_item.green;
            n_task.sector = rgbhsl_pkg::SEC_BLUE;
        end

        n_task.sum    = sum;
        n_task.spread = mx - mn;
        n_task.den    = (sum < SW'(rgbhsl_pkg::HALF_SUM))
                      ? sum[CW-1:0]
                      : CW'(SW'(rgbhsl_pkg::FULL_SUM) - sum);
        n_task.neg    = pos < neg;
        n_task.diff   = (pos < neg) ? neg - pos : pos - neg;
    end

    assign o_push  = r_valid && !i_q_full;
    assign take    = !r_valid || o_push;
    assign o_stall = !take;
    assign o_task  = r_task;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_valid) begin
            r_task <= n_task;
        end
    end

endmodule

// ----- hw/rtl/rgbhsl_fifo.sv -----
module rgbhsl_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rgbhsl_pkg::t_task i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output rgbhsl_pkg::t_task o_data
);

    localparam int PW = rgbhsl_pkg::QPTR_W;
    localparam int CW = rgbhsl_pkg::QCNT_W;

    rgbhsl_pkg::t_task r_mem [rgbhsl_pkg::QDEPTH];
    logic [PW-1:0]     r_wptr;
    logic [PW-1:0]     r_rptr;
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     n_wptr;
    logic [PW-1:0]     n_rptr;
    logic [CW-1:0]     n_count;

    assign o_full  = r_count == CW'(rgbhsl_pkg::QDEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(rgbhsl_pkg::QDEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(rgbhsl_pkg::QDEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/rgbhsl_back.sv -----
module rgbhsl_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  rgbhsl_pkg::t_task     i_task,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output rgbhsl_pkg::t_out_item o_item
);

    localparam int NW = rgbhsl_pkg::NUM_W;
    localparam int DW = rgbhsl_pkg::DEN_W;
    localparam int QB = rgbhsl_pkg::DIV_BITS;
    localparam int YW = rgbhsl_pkg::LY_W;
    localparam int PW = rgbhsl_pkg::PCT_W;
    localparam int HW = rgbhsl_pkg::HUE_W;
    localparam int MW = YW + 9;

    logic adv;

    logic                r_p_valid;
    logic [NW-1:0]       r_p_sat_num;
    logic [DW-1:0]       r_p_sat_den;
    logic [NW-1:0]       r_p_hue_num;
    logic [DW-1:0]       r_p_hue_den;
    logic [YW-1:0]       r_p_y;
    rgbhsl_pkg::t_sector r_p_sector;
    logic                r_p_neg;
    logic                r_p_grey;

    logic [QB-1:0]       r_sd_valid;
    rgbhsl_pkg::t_side   r_sd [QB];

    logic                  r_out_valid;
    rgbhsl_pkg::t_out_item r_out;

    logic [QB-1:0] sat_q;
    logic [QB-1:0] hue_q;

    logic [MW-1:0]   lprod;
    logic [PW-1:0]   lq0;
    logic [YW-1:0]   lback;
    logic [YW-1:0]   lrem;
    rgbhsl_pkg::t_side sd1;
    logic [HW:0]     base;
    logic [HW:0]     hue_raw;
    logic [HW:0]     hue_wrap;
    rgbhsl_pkg::t_out_item n_out;

    assign adv   = !(r_out_valid && i_stall);
    assign o_pop = adv && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_sat_num <= NW'(i_task.spread) * NW'(rgbhsl_pkg::SAT_SCALE2) + NW'(i_task.den);
            r_p_sat_den <= {i_task.den, 1'b0};
            r_p_hue_num <= NW'(i_task.diff) * NW'(rgbhsl_pkg::HUE_SCALE2)
                         + NW'(i_task.spread) - NW'(i_task.neg);
            r_p_hue_den <= {i_task.spread, 1'b0};
            r_p_y       <= YW'(i_task.sum) * YW'(rgbhsl_pkg::LIGHT_MUL)
                         + YW'(rgbhsl_pkg::LIGHT_ADD);
            r_p_sector  <= i_task.sector;
            r_p_neg     <= i_task.neg;
            r_p_grey    <= i_task.spread == '0;
        end
    end

    rgbhsl_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_p_sat_num),
        .i_den (r_p_sat_den),
        .o_quo (sat_q)
    );

    rgbhsl_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_p_hue_num),
        .i_den (r_p_hue_den),
        .o_quo (hue_q)
    );

    always_comb begin
        lprod = MW'(r_p_y) * MW'(rgbhsl_pkg::LIGHT_RECIP);
        lq0   = PW'(lprod >> rgbhsl_pkg::LIGHT_SHIFT);
        lback = YW'(r_sd[0].light) * YW'(rgbhsl_pkg::LIGHT_DIV);
        lrem  = r_sd[0].y - lback;
        sd1   = r_sd[0];
        if (lrem >= YW'(rgbhsl_pkg::LIGHT_DIV)) begin
            sd1.light = r_sd[0].light + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd[0].sector <= r_p_sector;
            r_sd[0].neg    <= r_p_neg;
            r_sd[0].grey   <= r_p_grey;
            r_sd[0].y      <= r_p_y;
            r_sd[0].light  <= lq0;
            r_sd[1]        <= sd1;
            for (int k = 2; k < QB; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    always_comb begin
        base    = rgbhsl_pkg::sector_base(r_sd[QB-1].sector);
        hue_raw = r_sd[QB-1].neg
                ? base + (HW+1)'(rgbhsl_pkg::HUE_FULL) - (HW+1)'(hue_q)
                : base + (HW+1)'(hue_q);
        hue_wrap = (hue_raw >= (HW+1)'(rgbhsl_pkg::HUE_FULL))
                 ? hue_raw - (HW+1)'(rgbhsl_pkg::HUE_FULL)
                 : hue_raw;
        n_out.hue        = r_sd[QB-1].grey ? '0 : hue_wrap[HW-1:0];
        n_out.saturation = r_sd[QB-1].grey ? '0 : PW'(sat_q);
        n_out.lightness  = r_sd[QB-1].light;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_sd_valid  <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_p_valid   <= i_q_valid;
            r_sd_valid  <= {r_sd_valid[QB-2:0], r_p_valid};
            r_out_valid <= r_sd_valid[QB-1];
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ----- bench/rgb_to_hsl_converter_tb.sv -----
module rgb_to_hsl_converter_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [23:0] CORNER_RGB [0:19] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h7F7F7F,
        24'hFF0001, 24'hFFFFFE, 24'hFEFFFF, 24'hFE0000, 24'hC83737,
        24'hC93764, 24'h010000, 24'hFFFEFE, 24'hAA55FF, 24'h7F00FF
    };

    class hsl_scoreboard;
        rgbhsl_pkg::t_out_item expected_hsl[$];
        int errors = 0;

        function int unsigned div_nearest(int unsigned num, int unsigned den);
            return (2 * num + den) / (2 * den);
        endfunction

        function rgbhsl_pkg::t_out_item hsl_of(rgbhsl_pkg::t_in_item px);
            int unsigned r, g, b, hi, lo, s, d, den, pos, neg, base, n, hue_v, sat_v, light_v;
            rgbhsl_pkg::t_sector sec;
            rgbhsl_pkg::t_out_item res;
            r = px.red;
            g = px.green;
            b = px.blue;
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            s = hi + lo;
            d = hi - lo;
            hue_v = 0;
            sat_v = 0;
            if (d != 0) begin
                den = (s < rgbhsl_pkg::HALF_SUM) ? s : (rgbhsl_pkg::FULL_SUM - s);
                sat_v = div_nearest(10000 * d, den);
                // red wins a tie with green or blue, green wins a tie with blue
                if (hi == r) sec = rgbhsl_pkg::SEC_RED;
                else if (hi == g) sec = rgbhsl_pkg::SEC_GREEN;
                else sec = rgbhsl_pkg::SEC_BLUE;
                case (sec)
                    rgbhsl_pkg::SEC_RED: begin
                        pos = g; neg = b; base = 0;
                    end
                    rgbhsl_pkg::SEC_GREEN: begin
                        pos = b; neg = r; base = 2 * rgbhsl_pkg::HUE_SIXTH;
                    end
                    default: begin
                        pos = r; neg = g; base = 4 * rgbhsl_pkg::HUE_SIXTH;
                    end
                endcase
                if (pos >= neg) n = base * d + rgbhsl_pkg::HUE_SIXTH * (pos - neg);
                else n = base * d + rgbhsl_pkg::HUE_FULL * d
                         - rgbhsl_pkg::HUE_SIXTH * (neg - pos);
                hue_v = div_nearest(n, d);
                if (hue_v >= rgbhsl_pkg::HUE_FULL) hue_v -= rgbhsl_pkg::HUE_FULL;
            end
            light_v = div_nearest(10000 * s, rgbhsl_pkg::FULL_SUM);
            res.hue = hue_v[rgbhsl_pkg::HUE_W-1:0];
            res.saturation = sat_v[rgbhsl_pkg::PCT_W-1:0];
            res.lightness = light_v[rgbhsl_pkg::PCT_W-1:0];
            return res;
        endfunction

        function void note_pixel(rgbhsl_pkg::t_in_item px);
            expected_hsl.push_back(hsl_of(px));
        endfunction

        function void check_result(rgbhsl_pkg::t_out_item got);
            rgbhsl_pkg::t_out_item want;
            if (expected_hsl.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_hsl.pop_front();
            if (got.hue !== want.hue) begin
                $display("%0t hue: expected %0d, actual %0d", $time, want.hue, got.hue);
                errors++;
            end
            if (got.saturation !== want.saturation) begin
                $display("%0t saturation: expected %0d, actual %0d",
                         $time, want.saturation, got.saturation);
                errors++;
            end
            if (got.lightness !== want.lightness) begin
                $display("%0t lightness: expected %0d, actual %0d",
                         $time, want.lightness, got.lightness);
                errors++;
            end
        endfunction

        function int pending();
            return expected_hsl.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    rgbhsl_pkg::t_in_item  in_item = '0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    rgbhsl_pkg::t_out_item o_out_item;

    hsl_scoreboard board = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_reqs = 0;
    int cycles = 0;

    rgb_to_hsl_converter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL rgb_to_hsl_converter");
            $finish;
        end
    end

    initial begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rst_n && o_out_valid && !out_stall) board.check_result(o_out_item);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    task automatic send_pixel(input rgbhsl_pkg::t_in_item px);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= px;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_pixel(px);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    function automatic rgbhsl_pkg::t_in_item random_pixel();
        int unsigned v[3];
        int unsigned s, hi, tmp, j, mode;
        rgbhsl_pkg::t_in_item px;
        mode = $urandom_range(99);
        v[0] = $urandom_range(255);
        v[1] = $urandom_range(255);
        v[2] = $urandom_range(255);
        if (mode < 10) begin
            v[1] = v[0];
            v[2] = v[0];
        end else if (mode < 22) begin
            v[1] = v[0];
            v[2] = $urandom_range(v[0]);
        end else if (mode < 34) begin
            // sum of max and min around the light/dark boundary
            s = $urandom_range(254, 256);
            hi = $urandom_range((s + 1) / 2, (s < 255) ? s : 255);
            v[0] = hi;
            v[1] = s - hi;
            v[2] = $urandom_range(s - hi, hi);
        end else if (mode < 42) begin
            for (int k = 0; k < 3; k++)
                if ($urandom_range(1)) v[k] = $urandom_range(1) ? 255 : 0;
        end
        for (int k = 2; k > 0; k--) begin
            j = $urandom_range(k);
            tmp = v[k];
            v[k] = v[j];
            v[j] = tmp;
        end
        px.red = v[0][7:0];
        px.green = v[1][7:0];
        px.blue = v[2][7:0];
        return px;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (CORNER_RGB[k]) send_pixel(rgbhsl_pkg::t_in_item'(CORNER_RGB[k]));
        wait_drained();

        tx_idle_pct = 21;
        rx_idle_pct = 21;
        send_random(400);

        // fill the block behind a long output hold
        tx_idle_pct = 0;
        hold_reqs <= hold_reqs + 1;
        send_random(150);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(300);

        tx_idle_pct = 21;
        rx_idle_pct = 21;
        send_random(480);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS rgb_to_hsl_converter");
        end else begin
            $display("FAIL rgb_to_hsl_converter");
        end
        $finish;
    end
endmodule
